// File: hdl/nrmc_pkg.sv
// shared types, character codes and constant helpers for the rmc position parser
`default_nettype none
package nrmc_pkg;

  localparam int INT_W      = 17;
  localparam int FRAC_W     = 20;
  localparam int MIN_TOKENS = 7;
  localparam logic [INT_W-1:0] LAT_LIMIT = INT_W'(9999);
  localparam logic [INT_W-1:0] LON_LIMIT = INT_W'(99999);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UP_G  = 8'h47;
  localparam logic [7:0] CH_UP_P  = 8'h50;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_UP_R  = 8'h52;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_C  = 8'h43;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_S  = 8'h53;
  localparam logic [7:0] CH_UP_W  = 8'h57;

  typedef struct packed {
    logic [2:0] cnt;
    logic       dot;
    logic       stop;
    logic       ovf;
  } numfl_t;

  typedef struct packed {
    logic [INT_W-1:0]  ip;
    logic [FRAC_W-1:0] fp;
    logic [2:0]        cnt;
    logic              ovf;
  } coord_t;

  typedef struct packed {
    logic   ok;
    logic   south;
    logic   west;
    coord_t lat;
    coord_t lon;
  } rec_t;

  function automatic logic hdr_match(input logic [2:0] idx, input logic [7:0] c);
    logic m;
    case (idx)
      3'd0:    m = (c == CH_DOLLAR);
      3'd1:    m = (c == CH_UP_G);
      3'd2:    m = (c == CH_UP_P) || (c == CH_UP_N);
      3'd3:    m = (c == CH_UP_R);
      3'd4:    m = (c == CH_UP_M);
      3'd5:    m = (c == CH_UP_C);
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic longint pow10(input int k);
    longint p;
    case (k)
      0:       p = 64'd1;
      1:       p = 64'd10;
      2:       p = 64'd100;
      3:       p = 64'd1000;
      4:       p = 64'd10000;
      5:       p = 64'd100000;
      6:       p = 64'd1000000;
      default: p = 64'd10000000;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hdl/nrmc_ifs.sv
// valid/ready channel interfaces for input bytes and position results
`default_nettype none
interface nrmc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface nrmc_out_if;
  logic               valid;
  logic               ready;
  logic               position_updated;
  logic               position_valid;
  logic signed [27:0] latitude_microdeg;
  logic signed [30:0] longitude_microdeg;
  modport source(output valid, output position_updated, output position_valid,
                 output latitude_microdeg, output longitude_microdeg, input ready);
  modport sink(input valid, input position_updated, input position_valid,
               input latitude_microdeg, input longitude_microdeg, output ready);
endinterface
`default_nettype wire

// File: hdl/nrmc_front.sv
// line assembly, header match, tokenizer and coordinate digit accumulation
`default_nettype none
module nrmc_front #(
  parameter int LINE_MAX    = 128,
  parameter int FRAC_DIGITS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  nrmc_in_if.sink        in_ch,
  input  logic           space,
  output logic           push,
  output nrmc_pkg::rec_t rec
);
  import nrmc_pkg::*;

  localparam int LEN_W = $clog2(LINE_MAX);

  typedef struct packed {
    logic [INT_W-1:0]  ip;
    logic [FRAC_W-1:0] fp;
    numfl_t            fl;
  } numst_t;

  function automatic numst_t feed(input numst_t s, input logic [7:0] c,
                                  input logic [INT_W-1:0] limit);
    numst_t r;
    logic [INT_W+3:0] wide;
    logic [3:0] d;
    r = s;
    d = c[3:0];
    wide = '0;
    if (!s.fl.stop) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (!s.fl.dot) begin
          wide = {4'b0, s.ip} * (INT_W+4)'(10) + {{INT_W{1'b0}}, d};
          if (wide > {4'b0, limit}) begin
            r.ip = limit + INT_W'(1);
            r.fl.ovf = 1'b1;
          end else begin
            r.ip = wide[INT_W-1:0];
          end
        end else if (32'(s.fl.cnt) < FRAC_DIGITS) begin
          r.fp = s.fp * FRAC_W'(10) + {{(FRAC_W-4){1'b0}}, d};
          r.fl.cnt = s.fl.cnt + 3'd1;
        end
      end else if (c == CH_DOT && !s.fl.dot) begin
        r.fl.dot = 1'b1;
      end else begin
        r.fl.stop = 1'b1;
      end
    end
    return r;
  endfunction

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [2:0]       hp_r, hp_nxt;
  logic             hok_r, hok_nxt;
  logic [3:0]       tok_r, tok_nxt;
  logic             thc_r, thc_nxt;
  logic             stat_r, stat_nxt;
  logic             south_r, south_nxt;
  logic             west_r, west_nxt;
  numst_t           lat_r, lat_nxt;
  numst_t           lon_r, lon_nxt;

  logic       acc, is_end, first, clr;
  logic [7:0] c;
  logic [3:0] cur;

  assign in_ch.ready = space;
  assign acc    = in_ch.valid && in_ch.ready;
  assign c      = in_ch.data_byte;
  assign is_end = (c == CH_CR) || (c == CH_LF);
  assign push   = acc && is_end && (len_r != '0);

  assign rec.ok    = hok_r && (tok_r >= 4'(MIN_TOKENS)) && stat_r;
  assign rec.south = south_r;
  assign rec.west  = west_r;
  assign rec.lat   = '{ip: lat_r.ip, fp: lat_r.fp, cnt: lat_r.fl.cnt, ovf: lat_r.fl.ovf};
  assign rec.lon   = '{ip: lon_r.ip, fp: lon_r.fp, cnt: lon_r.fl.cnt, ovf: lon_r.fl.ovf};

  always_comb begin
    len_nxt = len_r;
    hp_nxt = hp_r;
    hok_nxt = hok_r;
    tok_nxt = tok_r;
    thc_nxt = thc_r;
    stat_nxt = stat_r;
    south_nxt = south_r;
    west_nxt = west_r;
    lat_nxt = lat_r;
    lon_nxt = lon_r;
    first = 1'b0;
    cur = '0;
    clr = acc && (is_end || (32'(len_r) >= LINE_MAX - 1));
    if (acc && !clr) begin
      len_nxt = len_r + LEN_W'(1);
      if (32'(len_r) < 6 && {{(LEN_W > 3 ? LEN_W-3 : 0){1'b0}}, hp_r} == len_r) begin
        if (hdr_match(hp_r, c)) begin
          hp_nxt = hp_r + 3'd1;
        end else begin
          hp_nxt = 3'd7;
        end
        if (hdr_match(hp_r, c) && hp_r == 3'd5) begin
          hok_nxt = 1'b1;
        end
      end
      if (c == CH_COMMA) begin
        thc_nxt = 1'b0;
      end else begin
        if (!thc_r) begin
          thc_nxt = 1'b1;
          first = 1'b1;
          if (tok_r != 4'd15) begin
            tok_nxt = tok_r + 4'd1;
          end
        end
        if (tok_nxt >= 4'd1 && tok_nxt <= 4'(MIN_TOKENS)) begin
          cur = tok_nxt - 4'd1;
          if (first && cur == 4'd2) stat_nxt = (c == CH_UP_A);
          if (first && cur == 4'd4 && c == CH_UP_S) south_nxt = 1'b1;
          if (first && cur == 4'd6 && c == CH_UP_W) west_nxt = 1'b1;
          if (cur == 4'd3) lat_nxt = feed(lat_r, c, LAT_LIMIT);
          if (cur == 4'd5) lon_nxt = feed(lon_r, c, LON_LIMIT);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      len_r <= '0;
      hp_r <= '0;
      hok_r <= 1'b0;
      tok_r <= '0;
      thc_r <= 1'b0;
      stat_r <= 1'b0;
      south_r <= 1'b0;
      west_r <= 1'b0;
      lat_r <= '0;
      lon_r <= '0;
    end else begin
      len_r <= len_nxt;
      hp_r <= hp_nxt;
      hok_r <= hok_nxt;
      tok_r <= tok_nxt;
      thc_r <= thc_nxt;
      stat_r <= stat_nxt;
      south_r <= south_nxt;
      west_r <= west_nxt;
      lat_r <= lat_nxt;
      lon_r <= lon_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/nrmc_fifo.sv
// short line record queue between the parser front and the conversion pipeline
`default_nettype none
module nrmc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  nrmc_pkg::rec_t wdata,
  output logic           space,
  input  logic           pop,
  output nrmc_pkg::rec_t rdata,
  output logic           avail
);
  import nrmc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  rec_t          mem [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign space = (cnt_r != (PW+1)'(DEPTH));
  assign avail = (cnt_r != '0);
  assign rdata = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (PW+1)'(DEPTH)))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue read while empty");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + (PW+1)'(1)))
    else $error("queue count lost a write");
`endif

endmodule
`default_nettype wire

// File: hdl/nrmc_back.sv
// coordinate conversion pipeline, stored position and result register
`default_nettype none
module nrmc_back #(
  parameter int FRAC_DIGITS = 5
) (
  input  logic           clk,
  input  logic           rst_n,
  input  nrmc_pkg::rec_t rec,
  input  logic           avail,
  output logic           pop,
  nrmc_out_if.source     out_ch
);
  import nrmc_pkg::*;

  localparam longint SCALE = pow10(FRAC_DIGITS);
  localparam longint GD    = (FRAC_DIGITS <= 5) ? pow10(FRAC_DIGITS + 1) : 64'd1000000;
  localparam longint MUL_A = 64'd1000000 / GD;
  localparam longint HALF  = 64'd30 * SCALE / GD;
  localparam longint DIV   = 2 * HALF;
  localparam longint RM    = SCALE * MUL_A;
  localparam longint RD    = (64'd1 << 34) / DIV;
  localparam longint R100  = (64'd1 << 24) / 100;
  localparam int N_W  = 28;
  localparam int Q_W  = 21;
  localparam int MI_W = 30;

  typedef struct packed {
    logic ok;
    logic south;
    logic west;
  } meta_t;

  logic       en;
  logic [7:1] v_r;
  meta_t      m_r [1:7];
  logic       upd_r, have_r;
  logic signed [27:0] lat_r;
  logic signed [30:0] lon_r;
  logic       out_valid_r;

  logic [INT_W-1:0]  ip1_r [2];
  logic [FRAC_W-1:0] fs1_r [2];
  logic [INT_W+17:0] pq1_r [2];
  logic [9:0]        q2_r [2];
  logic [INT_W-1:0]  t2_r [2];
  logic [INT_W-1:0]  ip2_r [2];
  logic [N_W-1:0]    fa2_r [2];
  logic [9:0]        dg3_r [2];
  logic [6:0]        rm3_r [2];
  logic [N_W-1:0]    fa3_r [2];
  logic [N_W-1:0]    n4_r [2];
  logic [MI_W-1:0]   dm4_r [2];
  logic [N_W+31:0]   pr5_r [2];
  logic [N_W-1:0]    n5_r [2];
  logic [MI_W-1:0]   dm5_r [2];
  logic [Q_W-1:0]    q6_r [2];
  logic [N_W-1:0]    qd6_r [2];
  logic [N_W-1:0]    n6_r [2];
  logic [MI_W-1:0]   dm6_r [2];
  logic [MI_W-1:0]   mi7_r [2];

  logic ok0;
  assign en  = !out_valid_r || out_ch.ready;
  assign pop = avail && en;
  assign ok0 = rec.ok && !rec.lat.ovf && !rec.lon.ovf
               && (rec.lat.ip != '0 || rec.lat.fp != '0)
               && (rec.lon.ip != '0 || rec.lon.fp != '0);

  for (genvar i = 0; i < 2; i++) begin : g_lane
    coord_t           cin;
    logic [FRAC_W-1:0] pw;
    logic [INT_W-1:0] rem0;
    logic [N_W-1:0]   chk;
    assign cin  = (i == 0) ? rec.lat : rec.lon;
    assign pw   = FRAC_W'(pow10(FRAC_DIGITS - int'(cin.cnt)));
    assign rem0 = ip2_r[i] - t2_r[i];
    assign chk  = n6_r[i] - qd6_r[i];

    always_ff @(posedge clk) begin
      if (en) begin
        // stage 1: scale fraction, reciprocal product for the degree split
        ip1_r[i] <= cin.ip;
        fs1_r[i] <= cin.fp * pw;
        pq1_r[i] <= {18'b0, cin.ip} * (INT_W+18)'(R100);
        // stage 2
        q2_r[i]  <= pq1_r[i][33:24];
        t2_r[i]  <= INT_W'({7'b0, pq1_r[i][33:24]} * INT_W'(100));
        ip2_r[i] <= ip1_r[i];
        fa2_r[i] <= {{(N_W-FRAC_W){1'b0}}, fs1_r[i]} * N_W'(MUL_A);
        // stage 3: fix the quotient estimate
        if (rem0 >= INT_W'(100)) begin
          dg3_r[i] <= q2_r[i] + 10'd1;
          rm3_r[i] <= 7'(rem0 - INT_W'(100));
        end else begin
          dg3_r[i] <= q2_r[i];
          rm3_r[i] <= 7'(rem0);
        end
        fa3_r[i] <= fa2_r[i];
        // stage 4: rounded minute numerator
        n4_r[i]  <= {{(N_W-7){1'b0}}, rm3_r[i]} * N_W'(RM) + fa3_r[i] + N_W'(HALF);
        dm4_r[i] <= {{(MI_W-10){1'b0}}, dg3_r[i]} * MI_W'(1000000);
        // stage 5
        pr5_r[i] <= {32'b0, n4_r[i]} * (N_W+32)'(RD);
        n5_r[i]  <= n4_r[i];
        dm5_r[i] <= dm4_r[i];
        // stage 6
        q6_r[i]  <= pr5_r[i][34+Q_W-1:34];
        qd6_r[i] <= N_W'({{(N_W-Q_W){1'b0}}, pr5_r[i][34+Q_W-1:34]} * N_W'(DIV));
        n6_r[i]  <= n5_r[i];
        dm6_r[i] <= dm5_r[i];
        // stage 7: correct quotient and add degrees
        mi7_r[i] <= dm6_r[i] + {{(MI_W-Q_W){1'b0}}, q6_r[i]}
                    + MI_W'(chk >= N_W'(DIV));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[1] <= '{ok: ok0, south: rec.south, west: rec.west};
      for (int k = 2; k <= 7; k++) begin
        m_r[k] <= m_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      out_valid_r <= 1'b0;
      upd_r <= 1'b0;
      have_r <= 1'b0;
      lat_r <= '0;
      lon_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], pop};
      out_valid_r <= v_r[7];
      upd_r <= v_r[7] && m_r[7].ok;
      if (v_r[7] && m_r[7].ok) begin
        have_r <= 1'b1;
        lat_r <= m_r[7].south ? -$signed(28'(mi7_r[0])) : $signed(28'(mi7_r[0]));
        lon_r <= m_r[7].west ? -$signed(31'(mi7_r[1])) : $signed(31'(mi7_r[1]));
      end
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.position_updated   = upd_r;
  assign out_ch.position_valid     = have_r;
  assign out_ch.latitude_microdeg  = lat_r;
  assign out_ch.longitude_microdeg = lon_r;

`ifndef SYNTH
  a_upd_has_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && upd_r) |-> have_r)
    else $error("update without stored position");
  a_have_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(have_r))
    else $error("stored position lost");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[7] && !en) |=> v_r[7])
    else $error("item dropped in stalled pipeline");
`endif

endmodule
`default_nettype wire

// File: hdl/nmea_rmc_position_parser.sv
// rmc sentence position parser: line front end, record queue, conversion back end
// takes one byte per cycle; the front end never stalls while the queue has room
// a line end's result passes through the queue, the seven-stage conversion and the output reg
// results leave at up to one per cycle; with the receiver always ready the queue never fills
// synchronous active-low reset clears line state, queue, pipeline and stored position
`default_nettype none
module nmea_rmc_position_parser #(
  parameter int LINE_MAX    = 128,
  parameter int FRAC_DIGITS = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  nrmc_in_if.sink    in_ch,
  nrmc_out_if.source out_ch
);
  import nrmc_pkg::*;

  rec_t wrec, rrec;
  logic push, space, pop, avail;

  nrmc_front #(.LINE_MAX(LINE_MAX), .FRAC_DIGITS(FRAC_DIGITS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .space(space), .push(push), .rec(wrec)
  );

  nrmc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .wdata(wrec), .space(space),
    .pop(pop), .rdata(rrec), .avail(avail)
  );

  nrmc_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
    .clk(clk), .rst_n(rst_n), .rec(rrec), .avail(avail), .pop(pop), .out_ch(out_ch)
  );

endmodule
`default_nettype wire

// File: bench/nrmc_position_checker.sv
// checker for the rmc position parser: tracks line state, predicts results, compares
module nrmc_position_checker #(
  parameter int LINE_MAX    = 128,
  parameter int FRAC_DIGITS = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [7:0]         in_data_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_position_updated,
  input  logic               out_position_valid,
  input  logic signed [27:0] out_latitude_microdeg,
  input  logic signed [30:0] out_longitude_microdeg,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count,
  output int                 update_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import nrmc_pkg::*;

  typedef struct packed {
    logic               updated;
    logic               valid;
    logic signed [27:0] lat;
    logic signed [30:0] lon;
  } fix_t;

  typedef struct {
    longint ip;
    longint fp;
    int     cnt;
    bit     dot;
    bit     stop;
    bit     ovf;
  } num_t;

  fix_t position_q[$];

  int     line_len;
  int     hdr_prog;
  bit     hdr_ok;
  int     tok_idx;
  bit     tok_has;
  bit     active;
  bit     south, west;
  num_t   lat_n, lon_n;
  longint st_lat, st_lon;
  bit     have_pos;

  function automatic void clear_line();
    line_len = 0; hdr_prog = 0; hdr_ok = 0; tok_idx = 0; tok_has = 0;
    active = 0; south = 0; west = 0;
    lat_n = '{0, 0, 0, 0, 0, 0};
    lon_n = '{0, 0, 0, 0, 0, 0};
  endfunction

  function automatic void take_digit(ref num_t n, input logic [7:0] c, input longint lim);
    if (n.stop) return;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      if (!n.dot) begin
        n.ip = n.ip * 10 + (c - CH_ZERO);
        if (n.ip > lim) begin
          n.ip = lim + 1;
          n.ovf = 1;
        end
      end else if (n.cnt < FRAC_DIGITS) begin
        n.fp = n.fp * 10 + (c - CH_ZERO);
        n.cnt++;
      end
    end else if (c == CH_DOT && !n.dot) begin
      n.dot = 1;
    end else begin
      n.stop = 1;
    end
  endfunction

  // minute part rounds half up on the magnitude
  function automatic bit to_microdeg(input num_t n, output longint micro);
    longint scale, f, m;
    scale = 1;
    for (int i = 0; i < FRAC_DIGITS; i++) scale *= 10;
    f = n.fp;
    for (int k = n.cnt; k < FRAC_DIGITS; k++) f *= 10;
    micro = 0;
    if (n.ovf || (n.ip == 0 && f == 0)) return 0;
    m = (n.ip % 100) * scale + f;
    micro = (n.ip / 100) * 1000000 + (m * 1000000 + 30 * scale) / (60 * scale);
    return 1;
  endfunction

  function automatic void predict_byte(input logic [7:0] c);
    longint la, lo;
    bit first;
    int cur;
    fix_t r;
    if (c == CH_LF || c == CH_CR) begin
      if (line_len == 0) return;
      r.updated = 0;
      if (hdr_ok && tok_idx >= MIN_TOKENS && active &&
          to_microdeg(lat_n, la) && to_microdeg(lon_n, lo)) begin
        st_lat = south ? -la : la;
        st_lon = west ? -lo : lo;
        have_pos = 1;
        r.updated = 1;
      end
      r.valid = have_pos;
      r.lat = st_lat[27:0];
      r.lon = st_lon[30:0];
      position_q.push_back(r);
      clear_line();
      return;
    end
    if (line_len >= LINE_MAX - 1) begin
      clear_line();
      return;
    end
    if (line_len < 6 && hdr_prog == line_len) begin
      hdr_prog = hdr_match(3'(line_len), c) ? hdr_prog + 1 : 7;
      if (hdr_prog == 6) hdr_ok = 1;
    end
    if (c == CH_COMMA) begin
      tok_has = 0;
    end else begin
      first = 0;
      if (!tok_has) begin
        tok_has = 1;
        first = 1;
        if (tok_idx < 15) tok_idx++;
      end
      if (tok_idx >= 1 && tok_idx <= MIN_TOKENS) begin
        cur = tok_idx - 1;
        if (first) begin
          if (cur == 2) active = (c == CH_UP_A);
          if (cur == 4 && c == CH_UP_S) south = 1;
          if (cur == 6 && c == CH_UP_W) west = 1;
        end
        if (cur == 3) take_digit(lat_n, c, 9999);
        else if (cur == 5) take_digit(lon_n, c, 99999);
      end
    end
    line_len++;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fix_t w;
    if (!rst_n) begin
      clear_line();
      have_pos = 0;
      st_lat = 0; st_lon = 0;
      position_q.delete();
      fail_count = 0;
      result_count <= 0; update_count <= 0;
    end else begin
      if (in_valid && in_ready) predict_byte(in_data_byte);
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (position_q.size() == 0) begin
          $display("%0t: result with no line end waiting", $realtime);
          fail_count++;
        end else begin
          w = position_q.pop_front();
          if (w.updated) update_count <= update_count + 1;
          if (out_position_updated !== w.updated)
            report_mismatch("position_updated", out_position_updated, w.updated);
          if (out_position_valid !== w.valid)
            report_mismatch("position_valid", out_position_valid, w.valid);
          if (out_latitude_microdeg !== w.lat)
            report_mismatch("latitude_microdeg", out_latitude_microdeg, w.lat);
          if (out_longitude_microdeg !== w.lon)
            report_mismatch("longitude_microdeg", out_longitude_microdeg, w.lon);
        end
      end
    end
    pending_count = position_q.size();
  end
endmodule

// File: bench/nmea_rmc_position_parser_tb.sv
// top of the rmc position parser bench: clock, reset, sentence stimulus and verdict
module nmea_rmc_position_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nrmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending_count, result_count, update_count;
  int   bytes_sent = 0;
  int   idle_cycles = 0;
  bit   hold_off = 0;
  bit   rx_stall_en = 1;

  nrmc_in_if  in_ch();
  nrmc_out_if out_ch();

  always #5 clk = ~clk;

  nmea_rmc_position_parser i_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  nrmc_position_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data_byte(in_ch.data_byte),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_position_updated(out_ch.position_updated),
    .out_position_valid(out_ch.position_valid),
    .out_latitude_microdeg(out_ch.latitude_microdeg),
    .out_longitude_microdeg(out_ch.longitude_microdeg),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count), .update_count(update_count));

  initial begin
    in_ch.valid = 0;
    in_ch.data_byte = 0;
    out_ch.ready = 0;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      gap = rx_stall_en ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17)) : 0;
      if (gap != 0 && !hold_off) begin
        out_ch.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  bit burst_mode = 0;

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
    if (gap != 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic string rand_digits(input int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(48, 57)))};
    return s;
  endfunction

  function automatic string rand_coord(input int int_digits);
    string s;
    int k;
    s = rand_digits(int_digits);
    k = $urandom_range(0, 9);
    if (k < 7) s = {s, ".", rand_digits($urandom_range(0, 8))};
    else if (k == 7) s = {s, "."};
    else if (k == 8) s = {s, ".", rand_digits(2), string'(8'($urandom_range(32, 126)))};
    return s;
  endfunction

  function automatic string rand_sentence();
    string s, hdr, st, ns, ew, eol;
    hdr = $urandom_range(0, 1) ? "$GPRMC" : "$GNRMC";
    if ($urandom_range(0, 9) == 0)
      hdr = {hdr.substr(0, 4), string'(8'($urandom_range(32, 126)))};
    st = ($urandom_range(0, 4) == 0) ? "V" : "A";
    ns = $urandom_range(0, 1) ? "S" : "N";
    ew = $urandom_range(0, 1) ? "W" : "E";
    s = {hdr, ",", rand_digits(6), ".00,", st, ",", rand_coord($urandom_range(1, 5)), ","};
    if ($urandom_range(0, 5) == 0) s = {s, ","};
    s = {s, ns, ",", rand_coord($urandom_range(1, 6)), ",", ew};
    if ($urandom_range(0, 1)) s = {s, ",0.5,54.7,191194,020.3,E*68"};
    eol = $urandom_range(0, 1) ? "\r\n" : "\n";
    return {s, eol};
  endfunction

  initial begin
    int kind;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed lines
    send_text("\r\n\n");
    send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4\r\n");
    send_text("$GNRMC,1,A,9959.99999,S,17959.999999,W\n");
    send_text("$GPRMC,,A,,3723.2475,,N,,12158.3416,W\n");
    send_text("$GPRMC,1,V,4807.038,N,01131.000,E\n");
    send_text("$GPRMC,1,A,0000.000,N,01131.000,E\n");
    send_text("$GPRMC,1,A,10000.1,N,01131.000,E\n");
    send_text("$GPRMC,1,A,4807.0,N,100000.0,E\n");
    send_text("$GPRMC,1,A,48-07.5,N,1.2.3,E\n");
    send_text("x$GPRMC,1,A,4807.038,N,01131.000,E\n");
    send_text("$GPRMCXY,1,A,0.00001,S,0.5,W\n");
    send_text("$GPRMC,1,A,4807.038,N,01131.000\n");
    send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80); send_text("\n");
    for (int i = 0; i < 130; i++) send_byte(8'($urandom_range(32, 126)));
    send_text("$GNRMC,2,A,0001,N,00001,E\r");

    // receiver holds off while the sender streams short lines
    hold_off = 1;
    burst_mode = 1;
    for (int i = 0; i < 16; i++) send_text("A\n");
    burst_mode = 0;

    // sender pauses until every expected result is back
    while (pending_count != 0) @(posedge clk);

    while (bytes_sent < 650) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) send_text(rand_sentence());
      else if (kind == 8) begin
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
      end else send_text("\n");
    end
    in_ch.valid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    $display("sent %0d bytes; %0d line results checked, %0d with a new position",
             bytes_sent, result_count, update_count);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
